@@ sv/window_average_min_max_unit_defines.svh @@
// Assertion macros shared by the window average, minimum and maximum unit.
`ifndef WINDOW_AVERAGE_MIN_MAX_UNIT_DEFINES_SVH
`define WINDOW_AVERAGE_MIN_MAX_UNIT_DEFINES_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is held.
`define WAMM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define WAMM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define WAMM_ASSERT(lbl, prop, msg)
`define WAMM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ sv/wamm_pkg.sv @@
// Package with the operation codes, register constants and control structs of the unit.
package wamm_pkg;

    // Operation codes carried in the func field.
    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Window length register.
    localparam int LEN_REG_W = 7;
    localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd64;

    // Command from the controller to the ring store.
    typedef struct packed {
        logic              start;
        logic [FUNC_W-1:0] func;
    } t_scan_ctl;

    // Status from the ring store back to the controller.
    typedef struct packed {
        logic busy;
        logic ent_valid;
        logic ent_last;
    } t_scan_stat;

endpackage

@@ sv/wamm_in_if.sv @@
// Input channel interface: operation and sample.
interface wamm_in_if
    import wamm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [FUNC_W-1:0]             func;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink   (input valid, input func, input sample, output ready);
endinterface

@@ sv/wamm_out_if.sv @@
// Output channel interface: window average, maximum and minimum.
interface wamm_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic signed [SAMPLE_BITS-1:0] minimum;

    modport source (output valid, output average, output maximum, output minimum, input ready);
    modport sink   (input valid, input average, input maximum, input minimum, output ready);
endinterface

@@ sv/wamm_ring.sv @@
// Ring store of samples with its clearing pass and read-modify-write scan.
module wamm_ring
    import wamm_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int LW          = 7,
    parameter int PW          = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_scan_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [LW-1:0]                 i_len,
    input  logic [PW-1:0]                 i_wpos,
    output t_scan_stat                    o_stat,
    output logic signed [SAMPLE_BITS-1:0] o_entry
);

    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;

    // Clearing pass after reset.
    logic          r_init;
    logic [PW-1:0] r_init_idx;

    // Scan state, latched when a transfer starts the scan.
    logic                          r_scan;
    logic [LW-1:0]                 r_idx;
    logic [FUNC_W-1:0]             r_func;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [LW-1:0]                 r_len;
    logic [PW-1:0]                 r_wpos;

    // Stage aligned with the registered read data.
    logic                          r_s1_valid;
    logic                          r_s1_last;
    logic                          r_s1_ovr;
    logic signed [SAMPLE_BITS-1:0] r_s1_val;

    logic [LW-1:0]                 w_idx_inc;
    logic                          w_last;
    logic                          w_ovr;
    logic signed [SAMPLE_BITS-1:0] w_ovr_val;
    logic                          w_we;
    logic [PW-1:0]                 w_waddr;
    logic signed [SAMPLE_BITS-1:0] w_wdata;

    // An entry is overwritten on fill and clear, and at the write position on insert.
    assign w_idx_inc = r_idx + LW'(1);
    assign w_last    = (w_idx_inc == r_len);
    assign w_ovr     = (r_func == FUNC_FILL) || (r_func == FUNC_CLEAR) ||
                       ((r_func == FUNC_INSERT) && (r_idx[PW-1:0] == r_wpos));
    assign w_ovr_val = (r_func == FUNC_CLEAR) ? '0 : r_sample;

    // Write port: the clearing pass has priority over the scan.
    always_comb begin
        if (r_init) begin
            w_we    = 1'b1;
            w_waddr = r_init_idx;
            w_wdata = '0;
        end else begin
            w_we    = r_scan && w_ovr;
            w_waddr = r_idx[PW-1:0];
            w_wdata = w_ovr_val;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_idx[PW-1:0]];
    end

    // Clearing pass sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b1;
            r_init_idx <= '0;
        end else if (r_init) begin
            r_init_idx <= r_init_idx + PW'(1);
            if (r_init_idx == PW'(DEPTH - 1)) begin
                r_init <= 1'b0;
            end
        end
    end

    // Scan control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan     <= 1'b0;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_valid <= r_scan;
            r_s1_last  <= r_scan && w_last;
            if (i_ctl.start) begin
                r_scan <= 1'b1;
                r_idx  <= '0;
            end else if (r_scan) begin
                r_idx <= w_idx_inc;
                if (w_last) begin
                    r_scan <= 1'b0;
                end
            end
        end
    end

    // Payload of the scan; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_func   <= i_ctl.func;
            r_sample <= i_sample;
            r_len    <= i_len;
            r_wpos   <= i_wpos;
        end
        r_s1_ovr <= w_ovr;
        r_s1_val <= w_ovr_val;
    end

    // Forward the written value in place of the stale read data.
    assign o_entry          = r_s1_ovr ? r_s1_val : r_rdata;
    assign o_stat.busy      = r_init;
    assign o_stat.ent_valid = r_s1_valid;
    assign o_stat.ent_last  = r_s1_last;

endmodule

@@ sv/wamm_div.sv @@
// Signed by unsigned restoring divider, one quotient bit per cycle, truncating toward zero.
module wamm_div #(
    parameter int SUM_W       = 23,
    parameter int LW          = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SUM_W-1:0]       i_dividend,
    input  logic [LW-1:0]                 i_divisor,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [SUM_W-1:0] r_quo;
    logic [LW-1:0]    r_rem;
    logic [LW-1:0]    r_dsr;

    logic [LW:0]      w_trial;
    logic             w_fit;
    logic [LW:0]      w_diff;
    logic [SUM_W-1:0] w_mag;
    logic [SUM_W-1:0] w_q;

    // Magnitude of the dividend and one restoring step.
    assign w_mag   = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient shifts in where the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= w_mag;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[LW-1:0] : w_trial[LW-1:0];
        end
    end

    // Restore the sign; the mean always lies within the sample range.
    assign w_q        = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_quotient = w_q[SAMPLE_BITS-1:0];
    assign o_done     = r_done;

endmodule

@@ sv/window_average_min_max_unit.sv @@
// Top level of the window average, minimum and maximum unit.
//
//   Channel   Direction  Transfer when          Payload
//   i_in      in         valid && ready         func, sample
//   o_out     out        valid && ready         average, maximum, minimum
//   i_cfg_*   in         i_cfg_we               window_len
//
// Each item is a scan over the single read port of the ring memory,
// one entry a cycle, followed by the divider, which makes one quotient bit a cycle.
// After reset a clearing pass zeroes the memory; no item is taken meanwhile.
// A finished result waits in the output register; the next item is taken while it waits.
`include "window_average_min_max_unit_defines.svh"

module window_average_min_max_unit
    import wamm_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wamm_in_if.sink              i_in,
    wamm_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [LEN_REG_W-1:0] i_cfg_wdata
);

    localparam int LW    = $clog2(DEPTH + 1);
    localparam int PW    = $clog2(DEPTH);
    localparam int SUM_W = SAMPLE_BITS + LW;
    localparam int CW    = (LW > LEN_REG_W) ? LW : LEN_REG_W;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_LOAD   = 3'd5;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [LEN_REG_W-1:0]          r_len_reg;
    logic [PW-1:0]                 r_wpos;
    logic                          r_first;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_avg;
    logic signed [SAMPLE_BITS-1:0] r_out_max;
    logic signed [SAMPLE_BITS-1:0] r_out_min;

    logic [CW-1:0]                 w_len_ext;
    logic [LW-1:0]                 w_len_eff;
    logic [PW-1:0]                 w_pos_now;
    logic [LW-1:0]                 w_pos_inc;
    logic [PW-1:0]                 w_pos_next;
    logic                          w_accept;
    logic                          w_out_free;
    t_scan_ctl                     w_ctl;
    t_scan_stat                    w_stat;
    logic signed [SAMPLE_BITS-1:0] w_entry;
    logic signed [SUM_W-1:0]       w_entry_ext;
    logic                          w_div_done;
    logic signed [SAMPLE_BITS-1:0] w_quotient;

    // Window length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_reg <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_len_reg <= i_cfg_wdata;
        end
    end

    // Effective length: zero acts as one, and anything above the depth as the depth.
    assign w_len_ext = CW'(r_len_reg);
    always_comb begin
        if (r_len_reg == '0) begin
            w_len_eff = LW'(1);
        end else if (w_len_ext > CW'(DEPTH)) begin
            w_len_eff = LW'(DEPTH);
        end else begin
            w_len_eff = w_len_ext[LW-1:0];
        end
    end

    // Write position: a stale position beyond the window restarts at entry zero.
    assign w_pos_now  = (LW'(r_wpos) >= w_len_eff) ? '0 : r_wpos;
    assign w_pos_inc  = LW'(w_pos_now) + LW'(1);
    assign w_pos_next = (w_pos_inc >= w_len_eff) ? '0 : w_pos_inc[PW-1:0];

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    assign w_ctl.start = w_accept;
    assign w_ctl.func  = i_in.func;

    // Ring memory with its scan.
    wamm_ring #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .LW          (LW),
        .PW          (PW)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_in.sample),
        .i_len    (w_len_eff),
        .i_wpos   (w_pos_now),
        .o_stat   (w_stat),
        .o_entry  (w_entry)
    );

    // Divider for the mean.
    wamm_div #(
        .SUM_W       (SUM_W),
        .LW          (LW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DSTART),
        .i_dividend (r_sum),
        .i_divisor  (w_len_eff),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (!w_stat.busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_stat.ent_valid && w_stat.ent_last) begin
                    n_state = ST_DSTART;
                end
            end
            ST_DSTART: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Write position update on insert and clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
        end else if (w_accept) begin
            if (i_in.func == FUNC_INSERT) begin
                r_wpos <= w_pos_next;
            end else if (i_in.func == FUNC_CLEAR) begin
                r_wpos <= '0;
            end
        end
    end

    // Sum, maximum and minimum over the scanned entries.
    assign w_entry_ext = SUM_W'(w_entry);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first <= 1'b1;
        end else if (w_stat.ent_valid) begin
            r_first <= 1'b0;
            if (r_first) begin
                r_sum <= w_entry_ext;
                r_max <= w_entry;
                r_min <= w_entry;
            end else begin
                r_sum <= r_sum + w_entry_ext;
                if (w_entry > r_max) begin
                    r_max <= w_entry;
                end
                if (w_entry < r_min) begin
                    r_min <= w_entry;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_LOAD) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_LOAD) && w_out_free) begin
            r_avg     <= w_quotient;
            r_out_max <= r_max;
            r_out_min <= r_min;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.average = r_avg;
    assign o_out.maximum = r_out_max;
    assign o_out.minimum = r_out_min;

    // Checks.
    `WAMM_ASSERT(a_load_only, $rose(r_out_valid) |-> ($past(r_state) == ST_LOAD), "result loaded outside the load step")
    `WAMM_ASSERT(a_entry_in_scan, w_stat.ent_valid |-> (r_state == ST_SCAN), "entry delivered outside a scan")
    `WAMM_ASSERT(a_accept_scan, w_accept |=> (r_state == ST_SCAN), "accepted item did not start a scan")
    `WAMM_ASSERT(a_max_ge_min, o_out.valid |-> (o_out.maximum >= o_out.minimum), "maximum below minimum")

endmodule
